FILE: sv/agzc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// agzc_pkg
// Types, character codes and per-element helper functions shared by the
// gzip Accept-Encoding checker.
// ----------------------------------------------------------------------------
package agzc_pkg;

  localparam logic [7:0] CH_COMMA = 8'h2c;
  localparam logic [7:0] CH_SEMI  = 8'h3b;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_STAR  = 8'h2a;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_EQ    = 8'h3d;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LQ    = 8'h71;
  localparam logic [7:0] CH_UQ    = 8'h51;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5a;
  localparam logic [7:0] CASE_OFS = 8'h20;

  localparam logic [2:0] TOK_LEN_GZIP = 3'd4;
  localparam logic [2:0] TOK_LEN_STAR = 3'd1;
  localparam logic [2:0] TOK_LEN_MAX  = 3'd5;

  typedef enum logic [2:0] {
    PH_SKIP  = 3'b001,
    PH_TOKEN = 3'b010,
    PH_PARAM = 3'b100
  } parse_phase_e;

  typedef enum logic [4:0] {
    QV_IDLE = 5'b00001,
    QV_Q    = 5'b00010,
    QV_EQ   = 5'b00100,
    QV_ZERO = 5'b01000,
    QV_FRAC = 5'b10000
  } qv_phase_e;

  typedef struct packed {
    parse_phase_e phase;
    logic [2:0]   tok_len;
    logic         tok_gzip;
    logic         tok_star;
    qv_phase_e    qv;
    logic         pend_zero;
    logic         elem_qzero;
    logic         accepted;
  } agzc_state_t;

  localparam agzc_state_t STATE_RST = '{
    phase:      PH_SKIP,
    tok_len:    3'd0,
    tok_gzip:   1'b1,
    tok_star:   1'b0,
    qv:         QV_IDLE,
    pend_zero:  1'b0,
    elem_qzero: 1'b0,
    accepted:   1'b0
  };

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    return (c >= CH_UA && c <= CH_UZ) ? c + CASE_OFS : c;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB);
  endfunction

  function automatic logic [7:0] gzip_char(input logic [1:0] idx);
    logic [7:0] r;
    unique case (idx)
      2'd0: r = 8'h67;
      2'd1: r = 8'h7a;
      2'd2: r = 8'h69;
      default: r = 8'h70;
    endcase
    return r;
  endfunction

  function automatic agzc_state_t clear_element(input agzc_state_t s);
    agzc_state_t r;
    r            = s;
    r.tok_len    = 3'd0;
    r.tok_gzip   = 1'b1;
    r.tok_star   = 1'b0;
    r.qv         = QV_IDLE;
    r.pend_zero  = 1'b0;
    r.elem_qzero = 1'b0;
    return r;
  endfunction

  // fold the element verdict into the sticky accept
  function automatic agzc_state_t close_element(input agzc_state_t s);
    agzc_state_t r;
    logic        dis;
    logic        hit;
    r   = s;
    dis = s.elem_qzero | (((s.qv == QV_ZERO) || (s.qv == QV_FRAC)) & s.pend_zero);
    hit = ((s.tok_len == TOK_LEN_GZIP) & s.tok_gzip) |
          ((s.tok_len == TOK_LEN_STAR) & s.tok_star);
    if (hit && !dis) begin
      r.accepted = 1'b1;
    end
    r       = clear_element(r);
    r.phase = PH_SKIP;
    return r;
  endfunction

  function automatic agzc_state_t scan_param(input agzc_state_t s, input logic [7:0] c);
    agzc_state_t r;
    r = s;
    unique case (s.qv)
      QV_Q: begin
        if (c == CH_EQ) r.qv = QV_EQ;
        else if (!is_blank(c)) r.qv = QV_IDLE;
      end
      QV_EQ: begin
        if (c == CH_ZERO) begin
          r.qv        = QV_ZERO;
          r.pend_zero = 1'b1;
        end else if (!is_blank(c)) begin
          r.qv = QV_IDLE;
        end
      end
      QV_ZERO: begin
        if (c == CH_DOT) begin
          r.qv = QV_FRAC;
        end else begin
          r.elem_qzero = 1'b1;
          r.qv         = QV_IDLE;
          r.pend_zero  = 1'b0;
        end
      end
      QV_FRAC: begin
        if (c >= CH_ZERO && c <= CH_NINE) begin
          if (c != CH_ZERO) r.pend_zero = 1'b0;
        end else begin
          if (s.pend_zero) r.elem_qzero = 1'b1;
          r.qv        = QV_IDLE;
          r.pend_zero = 1'b0;
        end
      end
      default: r.qv = QV_IDLE;
    endcase
    if (r.qv == QV_IDLE && (c == CH_LQ || c == CH_UQ)) begin
      r.qv = QV_Q;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: sv/agzc_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// agzc_step
// Next-state logic for one header byte: token match, q value scan, element
// close and end-of-header verdict.
// ----------------------------------------------------------------------------
module agzc_step (
  input  agzc_pkg::agzc_state_t st_i,
  input  logic [7:0]            byte_i,
  input  logic                  last_i,
  input  logic                  no_char_i,
  output agzc_pkg::agzc_state_t st_o,
  output logic                  gzip_o
);
  import agzc_pkg::*;

  agzc_state_t s;
  agzc_state_t t;

  always_comb begin
    s = st_i;
    if (!no_char_i) begin
      unique case (st_i.phase)
        PH_TOKEN: begin
          if (byte_i == CH_COMMA) begin
            s = close_element(st_i);
          end else if (byte_i == CH_SEMI || is_blank(byte_i)) begin
            s.phase = PH_PARAM;
            s       = scan_param(s, byte_i);
          end else begin
            if (st_i.tok_len < TOK_LEN_GZIP) begin
              if (fold_case(byte_i) != gzip_char(st_i.tok_len[1:0])) s.tok_gzip = 1'b0;
            end else begin
              s.tok_gzip = 1'b0;
            end
            s.tok_star = 1'b0;
            if (st_i.tok_len < TOK_LEN_MAX) s.tok_len = st_i.tok_len + 3'd1;
          end
        end
        PH_PARAM: begin
          if (byte_i == CH_COMMA) s = close_element(st_i);
          else s = scan_param(st_i, byte_i);
        end
        default: begin
          if (byte_i != CH_COMMA && !is_blank(byte_i)) begin
            s          = clear_element(st_i);
            s.phase    = PH_TOKEN;
            s.tok_len  = TOK_LEN_STAR;
            s.tok_gzip = (fold_case(byte_i) == gzip_char(2'd0));
            s.tok_star = (byte_i == CH_STAR);
          end
        end
      endcase
    end
  end

  // end of header: close the open element, report and restart
  always_comb begin
    t = s;
    if (s.phase == PH_TOKEN || s.phase == PH_PARAM) t = close_element(s);
  end

  assign gzip_o = t.accepted;
  assign st_o   = last_i ? STATE_RST : s;

endmodule
`default_nettype wire

FILE: sv/accept_encoding_gzip_check.sv
`default_nettype none
// ----------------------------------------------------------------------------
// accept_encoding_gzip_check
// Checks an Accept-Encoding header value, one byte per request, and reports
// on the last byte whether gzip (or a wildcard) is acceptable.
//
//   channel  direction  handshake              payload
//   in       input      in_valid_i/in_ready_o   header_byte_i, is_last_i, no_char_i
//   out      output     out_valid_o/out_ready_i gzip_accepted_o
//
// One request per cycle unless a stalled result holds a last byte. A byte is
// held in the input register; a last byte's verdict enters the result register.
// Reset clears the parser state and both valid flags.
// A stalled result holds only a last byte in the input register; other bytes
// keep flowing past it.
// ----------------------------------------------------------------------------
module accept_encoding_gzip_check (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] header_byte_i,
  input  logic       is_last_i,
  input  logic       no_char_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       gzip_accepted_o
);
  import agzc_pkg::*;

  logic        in_valid_q;
  logic [7:0]  byte_q;
  logic        last_q;
  logic        no_char_q;
  agzc_state_t state_q;
  agzc_state_t state_d;
  logic        gzip_d;
  logic        out_valid_q;
  logic        gzip_q;
  logic        adv;

  assign adv        = in_valid_q & (~last_q | ~out_valid_q | out_ready_i);
  assign in_ready_o = ~in_valid_q | adv;

  agzc_step u_step (
    .st_i      (state_q),
    .byte_i    (byte_q),
    .last_i    (last_q),
    .no_char_i (no_char_q),
    .st_o      (state_d),
    .gzip_o    (gzip_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= STATE_RST;
    end else begin
      if (in_ready_o) in_valid_q <= in_valid_i;
      if (adv) state_q <= state_d;
      if (adv && last_q) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      byte_q    <= header_byte_i;
      last_q    <= is_last_i;
      no_char_q <= no_char_i;
    end
    if (adv && last_q) gzip_q <= gzip_d;
  end

  assign out_valid_o     = out_valid_q;
  assign gzip_accepted_o = gzip_q;

endmodule
`default_nettype wire
